// ===== sv/esrm_pkg.sv =====
// Shared types and constants for the error symbol range mapper.
`timescale 1ns / 1ps

package esrm_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_SYM,
    ST_LOAD_BKT,
    ST_ENC_START,
    ST_AZ_MUL,
    ST_AZ_SUB,
    ST_AZ_CAP,
    ST_AZ_EMIT,
    ST_SYM_CMP,
    ST_SYM_EMIT,
    ST_BLEN,
    ST_DIV,
    ST_BKT_RD,
    ST_BKT_CHK,
    ST_BKT_LB,
    ST_RAW,
    ST_WAIT
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        borrow;
    logic [31:0] value;
  } alu_rsp_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] count;
  } tbl_entry_t;

  localparam int TBL_ENTRY_W = 64;

  localparam logic [1:0] MODE_LOAD_SYM = 2'd0;
  localparam logic [1:0] MODE_LOAD_BKT = 2'd1;
  localparam logic [1:0] MODE_ENCODE   = 2'd2;

  localparam logic [2:0] CFG_AFTER_ZERO      = 3'd0;
  localparam logic [2:0] CFG_ZERO_AFTER_ZERO = 3'd1;
  localparam logic [2:0] CFG_TRACKED         = 3'd2;
  localparam logic [2:0] CFG_BUCKET_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_LAST_BUCKET     = 3'd4;

  localparam logic [10:0] TRACKED_RESET      = 11'd1024;
  localparam logic [5:0]  BUCKET_WIDTH_RESET = 6'd2;
  localparam logic [5:0]  LAST_BUCKET_RESET  = 6'd0;

  // floor(x/500) = ((x>>2) * AZ_RECIP) >> AZ_SHIFT, exact for 32-bit x
  localparam logic [30:0] AZ_RECIP = 31'd1099511628;
  localparam int          AZ_SHIFT = 37;
  localparam int          PROD_W   = 61;

  localparam logic [5:0] FULL_RAW_WIDTH = 6'd32;
  localparam logic [2:0] LEN_LAST_STEP  = 3'd4;
  localparam logic [4:0] LEN_FIRST_SHIFT = 5'd16;

endpackage

// ===== sv/error_symbol_range_mapper.sv =====
// Error symbol range mapper: prediction errors to arithmetic-coder commands.
// Input channel (in_*): one transaction is a symbol-table load (mode 0), a
// bucket-table load (mode 1) or a value to encode (mode 2); mode 3 is dropped.
// Output channel (out_*): coder commands, range or raw bits, last_command set
// on the final command of a value. Loads give no command.
// Configuration (cfg_*): write-only registers; the user must see that they are
// written only while the block is idle, as the block does not enforce it.
// Throughput: one transaction at a time; in_ready is high only when idle. An
// in-range load writes its table entry and updates the running total. An encode
// after a zero value first gives an after-zero command; a tracked index then
// reads the symbol table for its command, and an escaped index adds a 5-step
// bit-length search, a 5-step quotient on the shared subtractor, a bucket read.
// Each command is computed after the previous one is taken. A stall on out_ready
// holds the command in the output register and stops the sequencer until taken.
// Reset clears the running totals, the after-zero flag and out_valid, and sets
// the configuration to its reset values; the tables are undefined until loaded.
`timescale 1ns / 1ps

module error_symbol_range_mapper #(
  parameter int SYMBOL_BITS    = 10,
  parameter int BUCKET_ENTRIES = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [10:0]        in_entry_index,
  input  logic [31:0]        in_entry_count,
  input  logic signed [31:0] in_error_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_command_kind,
  output logic [31:0]        out_range_total,
  output logic [31:0]        out_range_base,
  output logic [31:0]        out_range_size,
  output logic [31:0]        out_raw_bits,
  output logic [5:0]         out_raw_width,
  output logic               out_last_command,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import esrm_pkg::*;

  localparam int          SYM_ENTRIES = (1 << SYMBOL_BITS) + 1;
  localparam int          SYM_AW      = SYMBOL_BITS + 1;
  localparam int          BKT_AW      = $clog2(BUCKET_ENTRIES);
  localparam logic [31:0] TRK_MAX     = 32'(1 << SYMBOL_BITS);

  // configuration
  logic [31:0] azc_r, zazc_r;
  logic [10:0] trk_r;
  logic [5:0]  bw_r, lb_r;

  // control
  state_t      state_r, state_nxt, ret_r, ret_nxt;
  logic        prev_zero_r, prev_zero_nxt;
  logic [31:0] sym_rt_r, sym_rt_nxt, bkt_rt_r, bkt_rt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // payload
  logic [10:0]       idx_r, idx_nxt;
  logic [31:0]       cnt_r, cnt_nxt, val_r, val_nxt, zz_r, zz_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [31:0]       tot_r, tot_nxt, prob_r, prob_nxt, lim_r, lim_nxt;
  logic              esc_r, esc_nxt, ok_r, ok_nxt;
  logic [31:0]       tmp_r, tmp_nxt;
  logic [4:0]        n_r, n_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [4:0]        lenm1_r, lenm1_nxt, dsh_r, dsh_nxt, q_r, q_nxt;
  logic [5:0]        rem_r, rem_nxt;

  logic        out_kind_r, out_kind_nxt, out_last_r, out_last_nxt;
  logic [31:0] out_total_r, out_total_nxt, out_base_r, out_base_nxt;
  logic [31:0] out_size_r, out_size_nxt, out_bits_r, out_bits_nxt;
  logic [5:0]  out_width_r, out_width_nxt;

  // datapath helpers
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [31:0] trk_eff;
  logic [5:0]  bw_eff, lb_eff;
  logic        sym_idx_ok, bkt_idx_ok, q_in_range, val_is_zero;
  logic [31:0] load_base, bkt_size;
  logic [23:0] mn;
  logic [31:0] in_zz;
  logic [4:0]  sh;
  logic [5:0]  bits;
  logic [6:0]  rs, w7;
  logic [5:0]  w;

  // memories
  logic                   sym_we, bkt_we;
  logic [SYM_AW-1:0]      sym_raddr;
  logic [BKT_AW-1:0]      bkt_raddr;
  logic [TBL_ENTRY_W-1:0] sym_rdata, bkt_rdata, tbl_wdata;
  tbl_entry_t             sym_rd, bkt_rd;

  esrm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  esrm_mem #(
    .DEPTH (SYM_ENTRIES),
    .AW    (SYM_AW),
    .W     (TBL_ENTRY_W)
  ) u_sym_mem (
    .clk   (clk),
    .we    (sym_we),
    .waddr (SYM_AW'(idx_r)),
    .wdata (tbl_wdata),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  esrm_mem #(
    .DEPTH (BUCKET_ENTRIES),
    .AW    (BKT_AW),
    .W     (TBL_ENTRY_W)
  ) u_bkt_mem (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (BKT_AW'(idx_r)),
    .wdata (tbl_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  assign sym_rd = tbl_entry_t'(sym_rdata);
  assign bkt_rd = tbl_entry_t'(bkt_rdata);

  assign trk_eff = (trk_r == 11'd0) ? 32'd1 :
                   ({21'd0, trk_r} > TRK_MAX) ? TRK_MAX : {21'd0, trk_r};
  assign bw_eff  = (bw_r == 6'd0) ? 6'd1 : bw_r;
  assign lb_eff  = (32'(lb_r) >= 32'(BUCKET_ENTRIES)) ? 6'(BUCKET_ENTRIES - 1) : lb_r;

  assign sym_idx_ok  = 32'(idx_r) < 32'(SYM_ENTRIES);
  assign bkt_idx_ok  = 32'(idx_r) < 32'(BUCKET_ENTRIES);
  assign q_in_range  = 32'(q_r) < 32'(BUCKET_ENTRIES);
  assign val_is_zero = (val_r == 32'd0);
  assign bkt_size    = q_in_range ? bkt_rd.count : 32'd0;
  assign in_zz       = in_error_value[31] ? {~in_error_value[30:0], 1'b1}
                                          : {in_error_value[30:0], 1'b0};
  assign mn          = (prod_r[PROD_W-1:AZ_SHIFT] == 24'd0) ? 24'd1
                                                            : prod_r[PROD_W-1:AZ_SHIFT];
  assign sh          = LEN_FIRST_SHIFT >> step_r;
  assign rs          = {rem_r, dsh_r[4]};
  assign w7          = {2'd0, lenm1_r} - {1'b0, rem_r} + {1'b0, bw_eff};
  assign w           = (w7 > 7'(FULL_RAW_WIDTH)) ? FULL_RAW_WIDTH : w7[5:0];

  always_comb begin
    case (state_r)
      ST_LOAD_SYM: load_base = (idx_r == 11'd0) ? 32'd0 : sym_rt_r;
      ST_LOAD_BKT: load_base = (idx_r == 11'd0) ? 32'd0 : bkt_rt_r;
      default:     load_base = 32'd0;
    endcase
  end

  assign tbl_wdata = {load_base, cnt_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD_SYM: state_nxt = ST_LOAD_SYM;
            MODE_LOAD_BKT: state_nxt = ST_LOAD_BKT;
            MODE_ENCODE:   state_nxt = ST_ENC_START;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_SYM, ST_LOAD_BKT: state_nxt = ST_IDLE;
      ST_ENC_START: begin
        if (!prev_zero_r) begin
          state_nxt = ST_SYM_CMP;
        end else if (azc_r == 32'd0 || zazc_r == 32'd0) begin
          state_nxt = ST_AZ_EMIT;
        end else begin
          state_nxt = ST_AZ_MUL;
        end
      end
      ST_AZ_MUL:   state_nxt = ST_AZ_SUB;
      ST_AZ_SUB:   state_nxt = ST_AZ_CAP;
      ST_AZ_CAP:   state_nxt = ST_AZ_EMIT;
      ST_SYM_CMP:  state_nxt = ST_SYM_EMIT;
      ST_BLEN: begin
        if (step_r == LEN_LAST_STEP) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == LEN_LAST_STEP) state_nxt = ST_BKT_RD;
      end
      ST_BKT_RD:   state_nxt = ST_BKT_CHK;
      ST_BKT_CHK:  state_nxt = (bkt_size == 32'd0) ? ST_BKT_LB : ST_WAIT;
      ST_AZ_EMIT, ST_SYM_EMIT, ST_BKT_LB, ST_RAW: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!out_valid_r) state_nxt = ret_r;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready = (state_r == ST_IDLE);

    ret_nxt       = ret_r;
    prev_zero_nxt = prev_zero_r;
    sym_rt_nxt    = sym_rt_r;
    bkt_rt_nxt    = bkt_rt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    zz_nxt        = zz_r;
    prod_nxt      = prod_r;
    tot_nxt       = tot_r;
    prob_nxt      = prob_r;
    lim_nxt       = lim_r;
    esc_nxt       = esc_r;
    ok_nxt        = ok_r;
    tmp_nxt       = tmp_r;
    n_nxt         = n_r;
    step_nxt      = step_r;
    lenm1_nxt     = lenm1_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    out_total_nxt = out_total_r;
    out_base_nxt  = out_base_r;
    out_size_nxt  = out_size_r;
    out_bits_nxt  = out_bits_r;
    out_width_nxt = out_width_r;
    bits          = 6'd0;

    alu_req.op = ALU_SUB;
    alu_req.a  = 32'd0;
    alu_req.b  = 32'd0;
    sym_we     = 1'b0;
    bkt_we     = 1'b0;
    sym_raddr  = SYM_AW'(trk_eff);
    bkt_raddr  = BKT_AW'(lb_eff);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = in_entry_index;
          cnt_nxt = in_entry_count;
          val_nxt = $unsigned(in_error_value);
          zz_nxt  = in_zz;
        end
      end
      ST_LOAD_SYM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = load_base;
        alu_req.b  = cnt_r;
        if (sym_idx_ok) begin
          sym_we     = 1'b1;
          sym_rt_nxt = alu_rsp.value;
        end
      end
      ST_LOAD_BKT: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = load_base;
        alu_req.b  = cnt_r;
        if (bkt_idx_ok) begin
          bkt_we     = 1'b1;
          bkt_rt_nxt = alu_rsp.value;
        end
      end
      ST_ENC_START: begin
        prev_zero_nxt = val_is_zero;
        if (azc_r == 32'd0 || zazc_r == 32'd0) begin
          tot_nxt  = 32'd2;
          prob_nxt = 32'd1;
        end else begin
          tot_nxt  = azc_r;
          prob_nxt = zazc_r;
        end
      end
      ST_AZ_MUL: begin
        prod_nxt = azc_r[31:2] * AZ_RECIP;
      end
      ST_AZ_SUB: begin
        alu_req.a = tot_r;
        alu_req.b = {8'd0, mn};
        lim_nxt   = alu_rsp.value;
      end
      ST_AZ_CAP: begin
        alu_req.a = lim_r;
        alu_req.b = prob_r;
        if (alu_rsp.borrow) prob_nxt = lim_r;
      end
      ST_AZ_EMIT: begin
        alu_req.a     = tot_r;
        alu_req.b     = prob_r;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b0;
        out_total_nxt = tot_r;
        out_bits_nxt  = 32'd0;
        out_width_nxt = 6'd0;
        if (val_is_zero) begin
          out_base_nxt = 32'd0;
          out_size_nxt = prob_r;
          out_last_nxt = 1'b1;
          ret_nxt      = ST_IDLE;
        end else begin
          out_base_nxt = prob_r;
          out_size_nxt = alu_rsp.value;
          out_last_nxt = 1'b0;
          ret_nxt      = ST_SYM_CMP;
        end
      end
      ST_SYM_CMP: begin
        alu_req.a = zz_r;
        alu_req.b = trk_eff;
        esc_nxt   = ~alu_rsp.borrow;
        sym_raddr = alu_rsp.borrow ? SYM_AW'(zz_r) : SYM_AW'(trk_eff);
        tmp_nxt   = zz_r;
        n_nxt     = 5'd0;
        step_nxt  = 3'd0;
      end
      ST_SYM_EMIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b0;
        out_total_nxt = sym_rt_r;
        out_base_nxt  = sym_rd.base;
        out_size_nxt  = sym_rd.count;
        out_bits_nxt  = 32'd0;
        out_width_nxt = 6'd0;
        out_last_nxt  = ~esc_r;
        ret_nxt       = esc_r ? ST_BLEN : ST_IDLE;
      end
      ST_BLEN: begin
        if ((tmp_r >> sh) != 32'd0) begin
          tmp_nxt = tmp_r >> sh;
          n_nxt   = n_r + sh;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == LEN_LAST_STEP) begin
          bits      = {1'b0, n_nxt} + {5'd0, tmp_nxt[0]};
          lenm1_nxt = (bits == 6'd0) ? 5'd0 : 5'(bits - 6'd1);
          dsh_nxt   = lenm1_nxt;
          rem_nxt   = 6'd0;
          q_nxt     = 5'd0;
          step_nxt  = 3'd0;
        end
      end
      ST_DIV: begin
        alu_req.a = 32'(rs);
        alu_req.b = 32'(bw_eff);
        rem_nxt   = alu_rsp.borrow ? rs[5:0] : alu_rsp.value[5:0];
        q_nxt     = {q_r[3:0], ~alu_rsp.borrow};
        dsh_nxt   = {dsh_r[3:0], 1'b0};
        step_nxt  = (step_r == LEN_LAST_STEP) ? 3'd0 : step_r + 3'd1;
      end
      ST_BKT_RD: begin
        bkt_raddr = q_in_range ? BKT_AW'(q_r) : BKT_AW'(lb_eff);
      end
      ST_BKT_CHK: begin
        if (bkt_size == 32'd0) begin
          ok_nxt = 1'b0;
        end else begin
          ok_nxt        = ({1'b0, q_r} != lb_eff);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_total_nxt = bkt_rt_r;
          out_base_nxt  = bkt_rd.base;
          out_size_nxt  = bkt_size;
          out_bits_nxt  = 32'd0;
          out_width_nxt = 6'd0;
          out_last_nxt  = 1'b0;
          ret_nxt       = ST_RAW;
        end
      end
      ST_BKT_LB: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b0;
        out_total_nxt = bkt_rt_r;
        out_base_nxt  = bkt_rd.base;
        out_size_nxt  = bkt_rd.count;
        out_bits_nxt  = 32'd0;
        out_width_nxt = 6'd0;
        out_last_nxt  = 1'b0;
        ret_nxt       = ST_RAW;
      end
      ST_RAW: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b1;
        out_total_nxt = 32'd0;
        out_base_nxt  = 32'd0;
        out_size_nxt  = 32'd0;
        out_bits_nxt  = ok_r ? zz_r : val_r;
        out_width_nxt = ok_r ? w : FULL_RAW_WIDTH;
        out_last_nxt  = 1'b1;
        ret_nxt       = ST_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      prev_zero_r <= 1'b0;
      sym_rt_r    <= 32'd0;
      bkt_rt_r    <= 32'd0;
      out_valid_r <= 1'b0;
      azc_r       <= 32'd0;
      zazc_r      <= 32'd0;
      trk_r       <= TRACKED_RESET;
      bw_r        <= BUCKET_WIDTH_RESET;
      lb_r        <= LAST_BUCKET_RESET;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      prev_zero_r <= prev_zero_nxt;
      sym_rt_r    <= sym_rt_nxt;
      bkt_rt_r    <= bkt_rt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_AFTER_ZERO:      azc_r  <= cfg_wdata;
          CFG_ZERO_AFTER_ZERO: zazc_r <= cfg_wdata;
          CFG_TRACKED:         trk_r  <= cfg_wdata[10:0];
          CFG_BUCKET_WIDTH:    bw_r   <= cfg_wdata[5:0];
          CFG_LAST_BUCKET:     lb_r   <= cfg_wdata[5:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    val_r       <= val_nxt;
    zz_r        <= zz_nxt;
    prod_r      <= prod_nxt;
    tot_r       <= tot_nxt;
    prob_r      <= prob_nxt;
    lim_r       <= lim_nxt;
    esc_r       <= esc_nxt;
    ok_r        <= ok_nxt;
    tmp_r       <= tmp_nxt;
    n_r         <= n_nxt;
    step_r      <= step_nxt;
    lenm1_r     <= lenm1_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    out_total_r <= out_total_nxt;
    out_base_r  <= out_base_nxt;
    out_size_r  <= out_size_nxt;
    out_bits_r  <= out_bits_nxt;
    out_width_r <= out_width_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_command_kind = out_kind_r;
  assign out_range_total  = out_total_r;
  assign out_range_base   = out_base_r;
  assign out_range_size   = out_size_r;
  assign out_raw_bits     = out_bits_r;
  assign out_raw_width    = out_width_r;
  assign out_last_command = out_last_r;

endmodule

// ===== sv/esrm_alu.sv =====
// Shared 32-bit add/subtract unit with borrow out.
`timescale 1ns / 1ps

module esrm_alu (
  input  esrm_pkg::alu_req_t req,
  output esrm_pkg::alu_rsp_t rsp
);
  import esrm_pkg::*;

  logic [32:0] res;

  always_comb begin
    case (req.op)
      ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      default: res = '0;
    endcase
  end

  assign rsp.borrow = res[32];
  assign rsp.value  = res[31:0];

endmodule

// ===== sv/esrm_mem.sv =====
// Single-port-write, registered-read table memory.
`timescale 1ns / 1ps

module esrm_mem #(
  parameter int DEPTH = 33,
  parameter int AW    = 6,
  parameter int W     = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== bench/error_symbol_range_mapper_tb.sv =====
// Self-checking testbench for error_symbol_range_mapper: directed and random traffic.
`timescale 1ns / 1ps

module error_symbol_range_mapper_tb;
  import esrm_pkg::*;

  localparam int SYM_ENTRIES = 1025;
  localparam int SYM_LIMIT = 1024;
  localparam int BKT_ENTRIES = 33;
  localparam logic [31:0] AZ_DIVISOR = 32'd500;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int LONG_HOLD_AT = 100;
  localparam int RANDOM_PER_PHASE = 45;
  localparam int NUM_PHASES = 8;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic        cmd_kind;
    logic [31:0] rng_total;
    logic [31:0] rng_base;
    logic [31:0] rng_size;
    logic [31:0] raw_bits;
    logic [5:0]  raw_width;
    logic        last_cmd;
  } coder_cmd_t;

  class coder_command_model;
    logic [31:0] sym_count [SYM_ENTRIES];
    logic [31:0] sym_base [SYM_ENTRIES];
    bit          sym_loaded [SYM_ENTRIES];
    logic [31:0] bkt_count [BKT_ENTRIES];
    logic [31:0] bkt_base [BKT_ENTRIES];
    bit          bkt_loaded [BKT_ENTRIES];
    logic [31:0] sym_total;
    logic [31:0] bkt_total;
    bit          last_was_zero;
    logic [31:0] az_count;
    logic [31:0] zaz_count;
    logic [10:0] tracked;
    logic [5:0]  bkt_width;
    logic [5:0]  last_bkt;
    coder_cmd_t  expected_cmds[$];
    int          mismatches;
    int          encodes;
    int          loads;
    int          commands;

    function new();
      sym_total = '0;
      bkt_total = '0;
      last_was_zero = 1'b0;
      az_count = '0;
      zaz_count = '0;
      tracked = TRACKED_RESET;
      bkt_width = BUCKET_WIDTH_RESET;
      last_bkt = LAST_BUCKET_RESET;
      mismatches = 0;
      encodes = 0;
      loads = 0;
      commands = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_AFTER_ZERO:      az_count = data;
        CFG_ZERO_AFTER_ZERO: zaz_count = data;
        CFG_TRACKED:         tracked = data[10:0];
        CFG_BUCKET_WIDTH:    bkt_width = data[5:0];
        CFG_LAST_BUCKET:     last_bkt = data[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_tracked();
      int unsigned t;
      t = tracked;
      if (t == 0) t = 1;
      if (t > SYM_LIMIT) t = SYM_LIMIT;
      return t;
    endfunction

    function int unsigned eff_last();
      int unsigned lb;
      lb = last_bkt;
      if (lb >= BKT_ENTRIES) lb = BKT_ENTRIES - 1;
      return lb;
    endfunction

    function logic [31:0] zigzag(logic [31:0] v);
      return v[31] ? {~v[30:0], 1'b1} : {v[30:0], 1'b0};
    endfunction

    function int unsigned bucket_of(logic [31:0] zz);
      int unsigned bits;
      int unsigned bw;
      bits = 0;
      bw = (bkt_width == 0) ? 1 : bkt_width;
      for (int i = 31; i >= 0; i--) begin
        if (zz[i] && bits == 0) bits = i + 1;
      end
      return (bits == 0) ? 0 : (bits - 1) / bw;
    endfunction

    function coder_cmd_t range_cmd(logic [31:0] total, logic [31:0] base, logic [31:0] sz);
      coder_cmd_t c;
      c = '0;
      c.rng_total = total;
      c.rng_base = base;
      c.rng_size = sz;
      return c;
    endfunction

    function coder_cmd_t raw_cmd(logic [31:0] bits, logic [5:0] width);
      coder_cmd_t c;
      c = '0;
      c.cmd_kind = 1'b1;
      c.raw_bits = bits;
      c.raw_width = width;
      return c;
    endfunction

    // True when encoding v reads only table entries that have been loaded.
    function bit encode_is_defined(logic [31:0] v);
      logic [31:0] zz;
      int unsigned trk;
      int unsigned b;
      zz = zigzag(v);
      trk = eff_tracked();
      if (zz < trk) return sym_loaded[zz];
      if (!sym_loaded[trk]) return 1'b0;
      b = bucket_of(zz);
      if (b < BKT_ENTRIES && !bkt_loaded[b]) return 1'b0;
      if (b >= BKT_ENTRIES || bkt_count[b] == 0) return bkt_loaded[eff_last()];
      return 1'b1;
    endfunction

    function void predict_encode(logic [31:0] v);
      coder_cmd_t  seq[$];
      coder_cmd_t  tail;
      logic [31:0] zz;
      logic [31:0] prob;
      logic [31:0] total;
      logic [31:0] mn;
      logic [31:0] base;
      logic [31:0] sz;
      int unsigned trk;
      int unsigned bw;
      int unsigned lb;
      int unsigned b;
      int unsigned w;
      bit          prev;
      bit          ok;
      zz = zigzag(v);
      trk = eff_tracked();
      bw = (bkt_width == 0) ? 1 : bkt_width;
      lb = eff_last();
      prev = last_was_zero;
      last_was_zero = (v == 0);
      encodes++;
      if (prev) begin
        if (az_count == 0 || zaz_count == 0) begin
          prob = 32'd1;
          total = 32'd2;
        end else begin
          mn = az_count / AZ_DIVISOR;
          if (mn == 0) mn = 32'd1;
          total = az_count;
          prob = zaz_count;
          if (prob > total - mn) prob = total - mn;
        end
        if (v == 0) seq.push_back(range_cmd(total, '0, prob));
        else seq.push_back(range_cmd(total, prob, total - prob));
      end
      if (!(prev && v == 0)) begin
        if (zz < trk) begin
          seq.push_back(range_cmd(sym_total, sym_base[zz], sym_count[zz]));
        end else begin
          b = bucket_of(zz);
          sz = (b < BKT_ENTRIES) ? bkt_count[b] : '0;
          base = (b < BKT_ENTRIES) ? bkt_base[b] : '0;
          ok = 1'b1;
          seq.push_back(range_cmd(sym_total, sym_base[trk], sym_count[trk]));
          if (sz == 0) begin
            base = bkt_base[lb];
            sz = bkt_count[lb];
            ok = 1'b0;
          end else if (b == lb) begin
            ok = 1'b0;
          end
          seq.push_back(range_cmd(bkt_total, base, sz));
          if (ok) begin
            w = (b + 1) * bw;
            if (w > FULL_RAW_WIDTH) w = FULL_RAW_WIDTH;
            seq.push_back(raw_cmd(zz, w[5:0]));
          end else begin
            seq.push_back(raw_cmd(v, FULL_RAW_WIDTH));
          end
        end
      end
      tail = seq.pop_back();
      tail.last_cmd = 1'b1;
      seq.push_back(tail);
      foreach (seq[i]) expected_cmds.push_back(seq[i]);
    endfunction

    function void accept_item(logic [1:0] mode, logic [10:0] idx, logic [31:0] cnt,
                              logic [31:0] v);
      case (mode)
        MODE_LOAD_SYM: begin
          loads++;
          if (idx < SYM_ENTRIES) begin
            if (idx == 0) sym_total = '0;
            sym_base[idx] = sym_total;
            sym_count[idx] = cnt;
            sym_loaded[idx] = 1'b1;
            sym_total += cnt;
          end
        end
        MODE_LOAD_BKT: begin
          loads++;
          if (idx < BKT_ENTRIES) begin
            if (idx == 0) bkt_total = '0;
            bkt_base[idx] = bkt_total;
            bkt_count[idx] = cnt;
            bkt_loaded[idx] = 1'b1;
            bkt_total += cnt;
          end
        end
        MODE_ENCODE: predict_encode(v);
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      end
    endfunction

    function void compare_command(coder_cmd_t got);
      coder_cmd_t want;
      commands++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: command with nothing expected, expected none, actual %p", $time, got);
        return;
      end
      want = expected_cmds.pop_front();
      check_field("command_kind", want.cmd_kind, got.cmd_kind);
      check_field("range_total", want.rng_total, got.rng_total);
      check_field("range_base", want.rng_base, got.rng_base);
      check_field("range_size", want.rng_size, got.rng_size);
      check_field("raw_bits", want.raw_bits, got.raw_bits);
      check_field("raw_width", want.raw_width, got.raw_width);
      check_field("last_command", want.last_cmd, got.last_cmd);
      if (mismatches == MAX_REPORTS + 1)
        $display("%0t: further mismatch reports suppressed", $time);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = MODE_LOAD_SYM;
  logic [10:0]        in_entry_index = '0;
  logic [31:0]        in_entry_count = '0;
  logic signed [31:0] in_error_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_command_kind;
  logic [31:0]        out_range_total;
  logic [31:0]        out_range_base;
  logic [31:0]        out_range_size;
  logic [31:0]        out_raw_bits;
  logic [5:0]         out_raw_width;
  logic               out_last_command;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = CFG_AFTER_ZERO;
  logic [31:0]        cfg_wdata = '0;

  coder_command_model model = new();
  int unsigned cycle_count = 0;
  int unsigned tracked_span = 1;
  bit          sender_calm = 1'b0;

  error_symbol_range_mapper DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .in_entry_count   (in_entry_count),
    .in_error_value   (in_error_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_kind (out_command_kind),
    .out_range_total  (out_range_total),
    .out_range_base   (out_range_base),
    .out_range_size   (out_range_size),
    .out_raw_bits     (out_raw_bits),
    .out_raw_width    (out_raw_width),
    .out_last_command (out_last_command),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d commands outstanding", $time, model.expected_cmds.size());
      $display("error_symbol_range_mapper_tb NOT OK");
      $finish;
    end
  end

  // Command sink: random stalls, quiet stretches, and one long hold-off.
  initial begin : command_sink
    int         stall;
    int         taken;
    bit         calm;
    coder_cmd_t got;
    stall = 0;
    taken = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.cmd_kind = out_command_kind;
        got.rng_total = out_range_total;
        got.rng_base = out_range_base;
        got.rng_size = out_range_size;
        got.raw_bits = out_raw_bits;
        got.raw_width = out_raw_width;
        got.last_cmd = out_last_command;
        model.compare_command(got);
        taken++;
        if (taken % 30 == 0) calm = ($urandom_range(0, 2) == 0);
        stall = calm ? 0 : $urandom_range(0, 9);
        if (taken == LONG_HOLD_AT) stall = LONG_HOLD;
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= rst_n && (stall == 0);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [10:0] idx,
                           input logic [31:0] cnt, input logic [31:0] v);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_entry_index <= idx;
    in_entry_count <= cnt;
    in_error_value <= v;
    do @(posedge clk); while (!in_ready);
    model.accept_item(mode, idx, cnt, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (model.expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    model.write_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic logic [31:0] draw_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return $urandom;
    if (r == 3) return 32'hFFFF_FFFF;
    return $urandom_range(1, 2000);
  endfunction

  // Well-formed table build: symbols 0..span-1 plus the escape entry, then all buckets.
  task automatic load_tables();
    int unsigned trk;
    int unsigned span;
    trk = model.eff_tracked();
    span = $urandom_range(6, 20);
    if (span > trk) span = trk;
    for (int i = 0; i < span; i++) send_item(MODE_LOAD_SYM, i[10:0], draw_count(), $urandom);
    send_item(MODE_LOAD_SYM, trk[10:0], draw_count(), $urandom);
    for (int i = 0; i < BKT_ENTRIES; i++)
      send_item(MODE_LOAD_BKT, i[10:0], draw_count(), $urandom);
    tracked_span = span;
  endtask

  function automatic logic [31:0] draw_error_value();
    logic [31:0] zz;
    logic [31:0] v;
    int unsigned trk;
    int unsigned k;
    int unsigned sel;
    trk = model.eff_tracked();
    repeat (200) begin
      sel = $urandom_range(0, 99);
      if (sel < 18) begin
        zz = '0;
      end else if (sel < 45) begin
        zz = $urandom_range(0, tracked_span - 1);
      end else if (sel < 65) begin
        zz = trk + $urandom_range(0, 40);
      end else if (sel < 80) begin
        k = $urandom_range(0, 31);
        zz = (32'd1 << k) | ($urandom & ((32'd1 << k) - 1));
      end else if (sel < 92) begin
        zz = $urandom;
      end else begin
        zz = 32'hFFFF_FFFE | $urandom_range(0, 1);
      end
      v = zz[0] ? ~(zz >> 1) : (zz >> 1);
      if (model.encode_is_defined(v)) return v;
    end
    return '0;
  endfunction

  task automatic random_item(output bit counted);
    int unsigned r;
    logic [10:0] idx;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 75) begin
      send_item(MODE_ENCODE, $urandom, $urandom, draw_error_value());
    end else if (r < 83) begin
      case ($urandom_range(0, 2))
        0: idx = '0;
        1: idx = $urandom_range(0, tracked_span);
        default: idx = $urandom_range(0, SYM_LIMIT);
      endcase
      send_item(MODE_LOAD_SYM, idx, draw_count(), $urandom);
    end else if (r < 90) begin
      send_item(MODE_LOAD_BKT, $urandom_range(0, 40), draw_count(), $urandom);
    end else if (r < 95) begin
      send_item(MODE_UNUSED, $urandom, $urandom, $urandom);
      counted = 1'b0;
    end else begin
      send_item(r[0] ? MODE_LOAD_SYM : MODE_LOAD_BKT, $urandom_range(SYM_ENTRIES, 2047),
                $urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    int          counted;
    bit          c;
    logic [31:0] az;
    logic [31:0] zaz;
    logic [31:0] trk;
    logic [31:0] bw;
    logic [31:0] lb;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, table edges, ignored loads, zero runs, escapes.
    send_item(MODE_LOAD_SYM, 11'd0, 32'd0, 32'd0);
    send_item(MODE_LOAD_SYM, 11'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_LOAD_SYM, 11'd2, 32'd7, 32'd0);
    send_item(MODE_LOAD_SYM, 11'd1024, 32'd5, 32'd0);
    send_item(MODE_LOAD_SYM, 11'h7FF, 32'd9, 32'd0);
    send_item(MODE_LOAD_BKT, 11'd0, 32'd3, 32'd0);
    send_item(MODE_LOAD_BKT, 11'd5, 32'hFFFF_FFFF, 32'd0);
    send_item(MODE_LOAD_BKT, 11'd15, 32'd0, 32'd0);
    send_item(MODE_LOAD_BKT, 11'h7FF, 32'd1, 32'd0);
    send_item(MODE_UNUSED, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'd0);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'd0);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'd1);
    send_item(MODE_ENCODE, 11'd0, 32'd0, -32'sd1);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'd600);
    send_item(MODE_ENCODE, 11'd0, 32'd0, -32'sd600);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'h7FFF_FFFF);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'h8000_0000);
    send_item(MODE_ENCODE, 11'd0, 32'd0, 32'd0);
    send_item(MODE_ENCODE, 11'd0, 32'd0, -32'sd1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin az = 0; zaz = 5; trk = 0; bw = 0; lb = 63; end
        1: begin az = 32'hFFFF_FFFF; zaz = 32'hFFFF_FFFF; trk = 2047; bw = 63; lb = 32; end
        2: begin az = 1; zaz = 1; trk = 1; bw = 1; lb = 0; end
        3: begin az = 1000; zaz = 3; trk = 16; bw = 20; lb = 1; end
        4: begin az = 499; zaz = 600; trk = 1024; bw = 32; lb = 31; end
        default: begin
          az = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 5000);
          zaz = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, az);
          trk = $urandom_range(1, 40);
          bw = $urandom_range(1, 12);
          lb = $urandom_range(0, 40);
        end
      endcase
      write_reg(CFG_AFTER_ZERO, az);
      write_reg(CFG_ZERO_AFTER_ZERO, zaz);
      write_reg(CFG_TRACKED, ($urandom & 32'hFFFF_F800) | trk);
      write_reg(CFG_BUCKET_WIDTH, ($urandom & 32'hFFFF_FFC0) | bw);
      write_reg(CFG_LAST_BUCKET, ($urandom & 32'hFFFF_FFC0) | lb);
      cfg_we <= 1'b0;
      @(posedge clk);
      sender_calm = ($urandom_range(0, 3) == 0);
      load_tables();
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        random_item(c);
        counted += c;
      end
      drain();
    end

    $display("Run covered %0d encoded values and %0d table loads, %0d coder commands checked,",
             model.encodes, model.loads, model.commands);
    $display("over %0d register settings with extremes, %0d mismatches",
             NUM_PHASES + 1, model.mismatches);
    if (model.mismatches == 0 && model.expected_cmds.size() == 0) begin
      $display("error_symbol_range_mapper_tb OK");
    end else begin
      $display("error_symbol_range_mapper_tb NOT OK");
    end
    $finish;
  end

endmodule
